[hw/rtl/tlpc_pkg.sv]
// Shared types and constants for the traffic light controller with pedestrian
// walk requests and red-light camera. No dependencies.
package tlpc_pkg;

  typedef logic [13:0] period_t;
  typedef logic [2:0]  phase_t;
  typedef logic [1:0]  mode_t;
  typedef logic [2:0]  event_t;

  localparam period_t FIXED_PERIOD = 14'd1000;

  localparam int NUM_REGS = 7;
  localparam logic [2:0] REG_ALL_RED_A = 3'd0;
  localparam logic [2:0] REG_GREEN_NS  = 3'd1;
  localparam logic [2:0] REG_YELLOW_NS = 3'd2;
  localparam logic [2:0] REG_ALL_RED_B = 3'd3;
  localparam logic [2:0] REG_GREEN_EW  = 3'd4;
  localparam logic [2:0] REG_YELLOW_EW = 3'd5;
  localparam logic [2:0] REG_GRACE     = 3'd6;

  localparam period_t RST_ALL_RED = 14'd500;
  localparam period_t RST_GREEN   = 14'd6000;
  localparam period_t RST_YELLOW  = 14'd2000;
  localparam period_t RST_GRACE   = 14'd2000;

  localparam phase_t PH_RR_A = 3'd0;
  localparam phase_t PH_GR   = 3'd1;
  localparam phase_t PH_YR   = 3'd2;
  localparam phase_t PH_RR_B = 3'd3;
  localparam phase_t PH_RG   = 3'd4;
  localparam phase_t PH_RY   = 3'd5;

  localparam mode_t MODE_SIMPLE = 2'd0;
  localparam mode_t MODE_PED    = 2'd1;
  localparam mode_t MODE_CONFIG = 2'd2;
  localparam mode_t MODE_CAMERA = 2'd3;

  localparam event_t EV_NONE     = 3'd0;
  localparam event_t EV_SNAPSHOT = 3'd1;
  localparam event_t EV_ARMED    = 3'd2;
  localparam event_t EV_GREEN    = 3'd3;
  localparam event_t EV_LEFT     = 3'd4;

  localparam logic [1:0] VEH_NONE    = 2'd0;
  localparam logic [1:0] VEH_PRESENT = 2'd1;
  localparam logic [1:0] VEH_GREEN   = 2'd2;

  // walk flag bits
  localparam int WF_NS_PRESS = 0;
  localparam int WF_EW_PRESS = 1;
  localparam int WF_NS_QUEUE = 2;
  localparam int WF_EW_QUEUE = 3;
  localparam int WF_NS_SHOWN = 4;
  localparam int WF_EW_SHOWN = 5;

  localparam logic [7:0] WALK_NS_LIGHTS = 8'h61;
  localparam logic [7:0] WALK_EW_LIGHTS = 8'h8C;

  typedef struct packed {
    phase_t phase;
    mode_t  mode;
    logic   commit;
  } phase_info_t;

  typedef struct packed {
    logic [7:0]  lights;
    logic        ped_ns_waiting;
    logic        ped_ew_waiting;
    phase_t      phase;
    mode_t       active_mode;
    event_t      camera_event;
    logic [23:0] vehicle_time_ms;
  } result_t;

  function automatic logic [7:0] phase_lights(input phase_t ph);
    logic [7:0] l;
    case (ph)
      PH_RR_A: l = 8'h24;
      PH_GR:   l = 8'h21;
      PH_YR:   l = 8'h22;
      PH_RR_B: l = 8'h24;
      PH_RG:   l = 8'h0C;
      PH_RY:   l = 8'h14;
      default: l = 8'h24;
    endcase
    return l;
  endfunction

  function automatic period_t at_least_one(input period_t v);
    return (v == '0) ? 14'd1 : v;
  endfunction

endpackage

[hw/rtl/tlpc_ifs.sv]
// Handshake channel interfaces: tick items, result items, register writes.
// Depends on nothing.
interface tlpc_item_if;
  logic       valid;
  logic       ready;
  logic       ped_ns_press;
  logic       ped_ew_press;
  logic       car_press;
  logic [1:0] mode_switch;
  modport source(output valid, ped_ns_press, ped_ew_press, car_press, mode_switch,
                 input ready);
  modport sink(input valid, ped_ns_press, ped_ew_press, car_press, mode_switch,
               output ready);
endinterface

interface tlpc_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  lights;
  logic        ped_ns_waiting;
  logic        ped_ew_waiting;
  logic [2:0]  phase;
  logic [1:0]  active_mode;
  logic [2:0]  camera_event;
  logic [23:0] vehicle_time_ms;
  modport source(output valid, lights, ped_ns_waiting, ped_ew_waiting, phase,
                 active_mode, camera_event, vehicle_time_ms, input ready);
  modport sink(input valid, lights, ped_ns_waiting, ped_ew_waiting, phase,
               active_mode, camera_event, vehicle_time_ms, output ready);
endinterface

interface tlpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [13:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/tlpc_timing.sv]
// Phase sequencer: phase countdown, switch edge detect and mode commit.
// Depends on tlpc_pkg.
module tlpc_timing import tlpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  mode_t                 sw,
  input  logic [5:0][13:0]      periods,
  output phase_info_t           info
);

  phase_t  phase, phase_mid, phase_next;
  mode_t   mode, mode_next;
  mode_t   last_sw;
  logic    pending, pend_mid, pending_next, commit;
  period_t countdown, cnt_mid, countdown_next;

  always_comb begin
    pend_mid = pending | (sw != last_sw);
    if (countdown > 14'd1) begin
      phase_mid = phase;
      cnt_mid   = countdown - 14'd1;
    end else begin
      phase_mid = (phase >= PH_RY) ? PH_RR_A : phase + 3'd1;
      cnt_mid   = (mode < MODE_CONFIG) ? FIXED_PERIOD : at_least_one(periods[phase_mid]);
    end
    commit = pend_mid && (phase_mid == PH_RR_A || phase_mid == PH_RR_B);
    if (commit) begin
      phase_next     = PH_RR_A;
      mode_next      = sw;
      countdown_next = (sw < MODE_CONFIG) ? FIXED_PERIOD : at_least_one(periods[0]);
      pending_next   = 1'b0;
    end else begin
      phase_next     = phase_mid;
      mode_next      = mode;
      countdown_next = cnt_mid;
      pending_next   = pend_mid;
    end
  end

  assign info.phase  = phase_next;
  assign info.mode   = mode_next;
  assign info.commit = commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_RR_A;
      mode      <= MODE_SIMPLE;
      last_sw   <= MODE_SIMPLE;
      pending   <= 1'b0;
      countdown <= FIXED_PERIOD;
    end else if (step) begin
      phase     <= phase_next;
      mode      <= mode_next;
      last_sw   <= sw;
      pending   <= pending_next;
      countdown <= countdown_next;
    end
  end

endmodule

[hw/rtl/tlpc_walk.sv]
// Pedestrian walk request latch and lamp pattern selection.
// Depends on tlpc_pkg.
module tlpc_walk import tlpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  phase_info_t info,
  input  logic        ns_press,
  input  logic        ew_press,
  output logic [7:0]  lights,
  output logic        ns_waiting,
  output logic        ew_waiting
);

  logic [5:0] flags, flags_next;

  always_comb begin
    flags_next = info.commit ? 6'd0 : flags;
    flags_next[WF_NS_PRESS] = flags_next[WF_NS_PRESS] | ns_press;
    flags_next[WF_EW_PRESS] = flags_next[WF_EW_PRESS] | ew_press;
    lights = phase_lights(info.phase);
    if (info.mode != MODE_SIMPLE) begin
      if (flags_next[WF_NS_QUEUE] && info.phase == PH_GR) begin
        lights = WALK_NS_LIGHTS;
        flags_next[WF_NS_SHOWN] = 1'b1;
      end else if (flags_next[WF_EW_QUEUE] && info.phase == PH_RG) begin
        lights = WALK_EW_LIGHTS;
        flags_next[WF_EW_SHOWN] = 1'b1;
      end
      if (flags_next[WF_NS_SHOWN] && info.phase == PH_YR) begin
        flags_next[WF_NS_PRESS] = 1'b0;
        flags_next[WF_NS_QUEUE] = 1'b0;
        flags_next[WF_NS_SHOWN] = 1'b0;
      end
      if (flags_next[WF_EW_SHOWN] && info.phase == PH_RY) begin
        flags_next[WF_EW_PRESS] = 1'b0;
        flags_next[WF_EW_QUEUE] = 1'b0;
        flags_next[WF_EW_SHOWN] = 1'b0;
      end
      if (flags_next[WF_NS_PRESS] && info.phase != PH_GR) begin
        flags_next[WF_NS_PRESS] = 1'b0;
        flags_next[WF_NS_QUEUE] = 1'b1;
      end
      if (flags_next[WF_EW_PRESS] && info.phase != PH_RG) begin
        flags_next[WF_EW_PRESS] = 1'b0;
        flags_next[WF_EW_QUEUE] = 1'b1;
      end
    end
  end

  assign ns_waiting = flags_next[WF_NS_PRESS] | flags_next[WF_NS_QUEUE];
  assign ew_waiting = flags_next[WF_EW_PRESS] | flags_next[WF_EW_QUEUE];

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= 6'd0;
    end else if (step) begin
      flags <= flags_next;
    end
  end

endmodule

[hw/rtl/tlpc_camera.sv]
// Red-light camera: vehicle tracking, snapshot timer and dwell counter.
// Depends on tlpc_pkg.
module tlpc_camera import tlpc_pkg::*; #(
  parameter int ELAPSED_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  phase_info_t info,
  input  logic        car,
  input  period_t     grace,
  output event_t      cam_event,
  output logic [23:0] report
);

  localparam int RW = (ELAPSED_BITS > 24) ? ELAPSED_BITS : 24;

  logic [1:0]              vstat, vstat_next;
  period_t                 ccount, ccount_next;
  logic [ELAPSED_BITS-1:0] elapsed, elapsed_next;
  logic [RW-1:0]           el_ext;
  logic                    fired, yellow;

  assign yellow = (info.phase == PH_YR) || (info.phase == PH_RY);

  always_comb begin
    vstat_next   = info.commit ? VEH_NONE : vstat;
    ccount_next  = info.commit ? '0 : ccount;
    elapsed_next = info.commit ? '0 : elapsed;
    cam_event    = EV_NONE;
    report       = 24'd0;
    el_ext       = '0;
    fired        = 1'b0;
    if (info.mode == MODE_CAMERA) begin
      if (vstat_next != VEH_NONE && elapsed_next != '1) begin
        elapsed_next = elapsed_next + 1'b1;
      end
      if (ccount_next != '0) begin
        ccount_next = ccount_next - 14'd1;
        fired = (ccount_next == '0) && (vstat_next != VEH_NONE);
      end
      if (car) begin
        if (vstat_next == VEH_NONE) begin
          elapsed_next = '0;
          if (info.phase == PH_RR_A || info.phase == PH_RR_B) begin
            cam_event  = EV_SNAPSHOT;
            vstat_next = VEH_PRESENT;
          end else if (yellow) begin
            cam_event   = EV_ARMED;
            vstat_next  = VEH_PRESENT;
            ccount_next = at_least_one(grace);
          end else begin
            cam_event  = EV_GREEN;
            vstat_next = VEH_GREEN;
          end
        end else begin
          cam_event    = EV_LEFT;
          el_ext       = RW'(elapsed_next);
          report       = (el_ext > RW'(24'hFFFFFF)) ? 24'hFFFFFF : el_ext[23:0];
          vstat_next   = VEH_NONE;
          ccount_next  = '0;
          elapsed_next = '0;
        end
      end else if (vstat_next == VEH_GREEN && yellow) begin
        cam_event   = EV_ARMED;
        vstat_next  = VEH_PRESENT;
        ccount_next = at_least_one(grace);
      end else if (fired) begin
        cam_event = EV_SNAPSHOT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vstat   <= VEH_NONE;
      ccount  <= '0;
      elapsed <= '0;
    end else if (step) begin
      vstat   <= vstat_next;
      ccount  <= ccount_next;
      elapsed <= elapsed_next;
    end
  end

endmodule

[hw/rtl/traffic_light_ped_camera_ctrl.sv]
// Traffic light controller top: input register, phase/walk/camera logic, result register.
// A tick is held in the input register and its result then in the result register; a result-side stall holds both.
// Throughput: one tick per cycle while the result side is ready; input register and result register decouple the sides.
// Reset (synchronous, rst high): phase 0 all red, mode 0, countdown 1000, walk and camera
// cleared, period registers back to their defaults. Depends on tlpc_pkg, tlpc_ifs.
module traffic_light_ped_camera_ctrl import tlpc_pkg::*; #(
  parameter int ELAPSED_BITS = 24
) (
  input  logic          clk,
  input  logic          rst,
  tlpc_item_if.sink     item,
  tlpc_result_if.source result,
  tlpc_cfg_if.sink      cfg
);

  period_t          regs [NUM_REGS];
  logic [5:0][13:0] periods;

  logic       in_valid;
  logic       in_ns, in_ew, in_car;
  mode_t      in_sw;
  logic       out_valid;
  result_t    res;
  logic       advance, step;

  phase_info_t info;
  logic [7:0]  lights;
  logic        ns_wait, ew_wait;
  event_t      cam_event;
  logic [23:0] report;

  assign advance    = !out_valid || result.ready;
  assign step       = in_valid && advance;
  assign item.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_ALL_RED_A] <= RST_ALL_RED;
      regs[REG_GREEN_NS]  <= RST_GREEN;
      regs[REG_YELLOW_NS] <= RST_YELLOW;
      regs[REG_ALL_RED_B] <= RST_ALL_RED;
      regs[REG_GREEN_EW]  <= RST_GREEN;
      regs[REG_YELLOW_EW] <= RST_YELLOW;
      regs[REG_GRACE]     <= RST_GRACE;
    end else if (cfg.valid && cfg.index <= REG_GRACE) begin
      regs[cfg.index] <= cfg.data;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      periods[i] = regs[i];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_ns  <= item.ped_ns_press;
      in_ew  <= item.ped_ew_press;
      in_car <= item.car_press;
      in_sw  <= item.mode_switch;
    end
  end

  tlpc_timing u_timing (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .sw      (in_sw),
    .periods (periods),
    .info    (info)
  );

  tlpc_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .info       (info),
    .ns_press   (in_ns),
    .ew_press   (in_ew),
    .lights     (lights),
    .ns_waiting (ns_wait),
    .ew_waiting (ew_wait)
  );

  tlpc_camera #(.ELAPSED_BITS(ELAPSED_BITS)) u_camera (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .info      (info),
    .car       (in_car),
    .grace     (regs[REG_GRACE]),
    .cam_event (cam_event),
    .report    (report)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.lights          <= lights;
      res.ped_ns_waiting  <= ns_wait;
      res.ped_ew_waiting  <= ew_wait;
      res.phase           <= info.phase;
      res.active_mode     <= info.mode;
      res.camera_event    <= cam_event;
      res.vehicle_time_ms <= report;
    end
  end

  assign result.valid           = out_valid;
  assign result.lights          = res.lights;
  assign result.ped_ns_waiting  = res.ped_ns_waiting;
  assign result.ped_ew_waiting  = res.ped_ew_waiting;
  assign result.phase           = res.phase;
  assign result.active_mode     = res.active_mode;
  assign result.camera_event    = res.camera_event;
  assign result.vehicle_time_ms = res.vehicle_time_ms;

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res.phase <= PH_RY)
    else $error("phase out of range");

  a_time_only_on_left: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.camera_event != EV_LEFT) |-> res.vehicle_time_ms == 24'd0)
    else $error("dwell time without vehicle-left event");

  a_walk_needs_ped_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res.lights == WALK_NS_LIGHTS || res.lights == WALK_EW_LIGHTS))
      |-> res.active_mode != MODE_SIMPLE)
    else $error("walk lamps in simple mode");

  a_held_tick_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("pending tick dropped");

endmodule

[verif/tb_traffic_light_ped_camera_ctrl.sv]
// Testbench for traffic_light_ped_camera_ctrl: directed and random 1 ms ticks checked
// against a cycle-accurate predictor of phases, walk requests and camera events.
// Depends on tlpc_pkg, tlpc_ifs and the controller RTL.
module tb_traffic_light_ped_camera_ctrl;
  import tlpc_pkg::*;

  localparam int ELAPSED_W      = 24;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 64;
  localparam int RANDOM_TICKS   = 120;
  localparam int MIN_SEGMENTS   = 7;
  localparam int SOAK_TICKS     = 1050;
  localparam int DRAIN_CYCLES   = 3;

  localparam int RX_FREE   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_BURSTY = 2;

  localparam int PROF_LOW    = 0;
  localparam int PROF_HIGH   = 1;
  localparam int PROF_RANDOM = 2;

  localparam logic [31:0] DWELL_MAX  = (32'd1 << ELAPSED_W) - 32'd1;
  localparam logic [31:0] REPORT_MAX = 32'h00FF_FFFF;
  // lamp pattern per phase, phase 0 in the low byte
  localparam logic [47:0] LAMP_TABLE = {8'h14, 8'h0C, 8'h24, 8'h22, 8'h21, 8'h24};

  typedef struct {
    bit         is_cfg;
    logic [2:0] reg_idx;
    period_t    reg_val;
    logic       ns;
    logic       ew;
    logic       car;
    mode_t      sw;
    bit         typed;
    result_t    want;
  } plan_row_t;

  logic clk;
  logic rst;

  tlpc_item_if   item_ch ();
  tlpc_result_if res_ch ();
  tlpc_cfg_if    cfg_ch ();

  traffic_light_ped_camera_ctrl #(.ELAPSED_BITS(ELAPSED_W)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  period_t    period_reg [NUM_REGS] = '{RST_ALL_RED, RST_GREEN, RST_YELLOW, RST_ALL_RED,
                                        RST_GREEN, RST_YELLOW, RST_GRACE};
  phase_t     cur_phase      = PH_RR_A;
  mode_t      cur_mode       = MODE_SIMPLE;
  mode_t      prev_sw        = MODE_SIMPLE;
  logic       change_waiting = 1'b0;
  period_t    phase_left     = FIXED_PERIOD;
  logic [5:0] walk_bits      = '0;
  logic [1:0] car_state      = VEH_NONE;
  period_t    grace_left     = '0;
  logic [31:0] dwell_count   = '0;

  result_t due_displays [$];

  int errors       = 0;
  int ticks_sent   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int holds_done   = 0;
  int walks_seen   = 0;
  int ev_seen [5]  = '{0, 0, 0, 0, 0};
  int quiet_cycles = 0;
  int rx_style     = RX_FREE;
  bit hold_req     = 1'b0;
  bit gaps_on      = 1'b0;
  int burst_left   = 0;

  function automatic period_t min_one(input period_t v);
    return (v == '0) ? period_t'(1) : v;
  endfunction

  function automatic period_t phase_time(input phase_t ph);
    if (cur_mode == MODE_SIMPLE || cur_mode == MODE_PED) return FIXED_PERIOD;
    return min_one(period_reg[ph]);
  endfunction

  function automatic result_t step_intersection(input logic ns, ew, car, input mode_t sw);
    result_t    r;
    event_t     ev;
    logic [23:0] dwell_out;
    logic       fired;
    logic [7:0] lamps;
    phase_t     s;
    ev = EV_NONE;
    dwell_out = '0;
    fired = 1'b0;

    if (sw != prev_sw) change_waiting = 1'b1;
    prev_sw = sw;

    if (phase_left > 1) begin
      phase_left--;
    end else begin
      cur_phase = (cur_phase >= PH_RY) ? PH_RR_A : cur_phase + 3'd1;
      phase_left = phase_time(cur_phase);
    end

    if (change_waiting && (cur_phase == PH_RR_A || cur_phase == PH_RR_B)) begin
      change_waiting = 1'b0;
      cur_mode = sw;
      cur_phase = PH_RR_A;
      phase_left = phase_time(PH_RR_A);
      walk_bits = '0;
      car_state = VEH_NONE;
      grace_left = '0;
      dwell_count = '0;
    end

    if (ns) walk_bits[WF_NS_PRESS] = 1'b1;
    if (ew) walk_bits[WF_EW_PRESS] = 1'b1;

    s = cur_phase;
    lamps = LAMP_TABLE[int'(s) * 8 +: 8];
    if (cur_mode != MODE_SIMPLE) begin
      if (walk_bits[WF_NS_QUEUE] && s == PH_GR) begin
        lamps = WALK_NS_LIGHTS;
        walk_bits[WF_NS_SHOWN] = 1'b1;
      end else if (walk_bits[WF_EW_QUEUE] && s == PH_RG) begin
        lamps = WALK_EW_LIGHTS;
        walk_bits[WF_EW_SHOWN] = 1'b1;
      end
      if (walk_bits[WF_NS_SHOWN] && s == PH_YR) begin
        walk_bits[WF_NS_PRESS] = 1'b0;
        walk_bits[WF_NS_QUEUE] = 1'b0;
        walk_bits[WF_NS_SHOWN] = 1'b0;
      end
      if (walk_bits[WF_EW_SHOWN] && s == PH_RY) begin
        walk_bits[WF_EW_PRESS] = 1'b0;
        walk_bits[WF_EW_QUEUE] = 1'b0;
        walk_bits[WF_EW_SHOWN] = 1'b0;
      end
      if (walk_bits[WF_NS_PRESS] && s != PH_GR) begin
        walk_bits[WF_NS_PRESS] = 1'b0;
        walk_bits[WF_NS_QUEUE] = 1'b1;
      end
      if (walk_bits[WF_EW_PRESS] && s != PH_RG) begin
        walk_bits[WF_EW_PRESS] = 1'b0;
        walk_bits[WF_EW_QUEUE] = 1'b1;
      end
    end

    if (cur_mode == MODE_CAMERA) begin
      if (car_state != VEH_NONE && dwell_count < DWELL_MAX) dwell_count++;
      if (grace_left != '0) begin
        grace_left--;
        if (grace_left == '0 && car_state != VEH_NONE) fired = 1'b1;
      end
      if (car) begin
        if (car_state == VEH_NONE) begin
          dwell_count = '0;
          if (s == PH_RR_A || s == PH_RR_B) begin
            ev = EV_SNAPSHOT;
            car_state = VEH_PRESENT;
          end else if (s == PH_YR || s == PH_RY) begin
            ev = EV_ARMED;
            car_state = VEH_PRESENT;
            grace_left = min_one(period_reg[REG_GRACE]);
          end else begin
            ev = EV_GREEN;
            car_state = VEH_GREEN;
          end
        end else begin
          ev = EV_LEFT;
          dwell_out = (dwell_count > REPORT_MAX) ? REPORT_MAX[23:0] : dwell_count[23:0];
          car_state = VEH_NONE;
          grace_left = '0;
          dwell_count = '0;
        end
      end else if (car_state == VEH_GREEN && (s == PH_YR || s == PH_RY)) begin
        ev = EV_ARMED;
        car_state = VEH_PRESENT;
        grace_left = min_one(period_reg[REG_GRACE]);
      end else if (fired) begin
        ev = EV_SNAPSHOT;
      end
    end

    r.lights = lamps;
    r.ped_ns_waiting = walk_bits[WF_NS_PRESS] | walk_bits[WF_NS_QUEUE];
    r.ped_ew_waiting = walk_bits[WF_EW_PRESS] | walk_bits[WF_EW_QUEUE];
    r.phase = cur_phase;
    r.active_mode = cur_mode;
    r.camera_event = ev;
    r.vehicle_time_ms = dwell_out;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR t=%0t result %0d: %s", $time, results_seen, what);
    errors++;
  endtask

  task automatic check_display(input result_t got, input result_t want);
    if (got.lights !== want.lights)
      report_mismatch($sformatf("lights got %h want %h", got.lights, want.lights));
    if (got.ped_ns_waiting !== want.ped_ns_waiting)
      report_mismatch($sformatf("ped_ns_waiting got %b want %b",
                                got.ped_ns_waiting, want.ped_ns_waiting));
    if (got.ped_ew_waiting !== want.ped_ew_waiting)
      report_mismatch($sformatf("ped_ew_waiting got %b want %b",
                                got.ped_ew_waiting, want.ped_ew_waiting));
    if (got.phase !== want.phase)
      report_mismatch($sformatf("phase got %0d want %0d", got.phase, want.phase));
    if (got.active_mode !== want.active_mode)
      report_mismatch($sformatf("active_mode got %0d want %0d",
                                got.active_mode, want.active_mode));
    if (got.camera_event !== want.camera_event)
      report_mismatch($sformatf("camera_event got %0d want %0d",
                                got.camera_event, want.camera_event));
    if (got.vehicle_time_ms !== want.vehicle_time_ms)
      report_mismatch($sformatf("vehicle_time_ms got %0d want %0d",
                                got.vehicle_time_ms, want.vehicle_time_ms));
  endtask

  task automatic send_tick(input logic ns, ew, car, input mode_t sw,
                           input bit typed = 1'b0, input result_t want = '0);
    result_t pred;
    if (gaps_on) begin
      if (burst_left == 0) begin
        item_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    item_ch.valid        <= 1'b1;
    item_ch.ped_ns_press <= ns;
    item_ch.ped_ew_press <= ew;
    item_ch.car_press    <= car;
    item_ch.mode_switch  <= sw;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pred = step_intersection(ns, ew, car, sw);
    due_displays.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (due_displays.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input period_t val);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx < NUM_REGS) period_reg[idx] = val;
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic load_periods(input int profile);
    period_t val;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (profile)
        PROF_LOW:  val = period_t'(1);
        PROF_HIGH: val = (i == REG_GRACE) ? 14'h3FFF : 14'd9999;
        default: begin
          if ($urandom_range(0, 9) == 0) val = '0;
          else if (i == REG_GRACE) val = period_t'($urandom_range(1, 12));
          else val = period_t'($urandom_range(1, 6));
        end
      endcase
      cfg_write(3'(i), val);
    end
    if (profile == PROF_LOW || $urandom_range(0, 3) == 0)
      cfg_write(3'(NUM_REGS), period_t'($urandom_range(0, 16383)));
  endtask

  // result checker
  always @(posedge clk) begin : display_checker
    result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.lights          = res_ch.lights;
      got.ped_ns_waiting  = res_ch.ped_ns_waiting;
      got.ped_ew_waiting  = res_ch.ped_ew_waiting;
      got.phase           = res_ch.phase;
      got.active_mode     = res_ch.active_mode;
      got.camera_event    = res_ch.camera_event;
      got.vehicle_time_ms = res_ch.vehicle_time_ms;
      if (due_displays.size() == 0) begin
        report_mismatch("result with no tick outstanding");
      end else begin
        check_display(got, due_displays.pop_front());
      end
      if (got.camera_event <= EV_LEFT) ev_seen[got.camera_event]++;
      if (got.lights == WALK_NS_LIGHTS || got.lights == WALK_EW_LIGHTS) walks_seen++;
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, due_displays.size());
      $display("FAIL traffic_light_ped_camera_ctrl");
      $finish;
    end
  end

  // result side ready pattern
  initial begin : display_sink
    int  stall_left;
    bit  open;
    stall_left = 0;
    open = 1'b1;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        holds_done++;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case (rx_style)
          RX_FREE:   res_ch.ready <= 1'b1;
          RX_RANDOM: res_ch.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            if (stall_left == 0) begin
              open = !open;
              stall_left = open ? $urandom_range(1, 16) : $urandom_range(1, 10);
            end
            stall_left--;
            res_ch.ready <= open;
          end
        endcase
      end
    end
  end

  function automatic plan_row_t tick_row(input logic ns, ew, car, input mode_t sw);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.ns      = ns;
    r.ew      = ew;
    r.car     = car;
    r.sw      = sw;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic ns, ew, car, input mode_t sw,
                                            input result_t want);
    plan_row_t r;
    r = tick_row(ns, ew, car, sw);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [2:0] idx, input period_t val);
    plan_row_t r;
    r = tick_row(1'b0, 1'b0, 1'b0, MODE_SIMPLE);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  initial begin
    plan_row_t plan [$];
    int        seg;
    int        len;
    int        start_ticks;
    mode_t     tgt;
    mode_t     sw;

    clk = 1'b0;
    rst = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.ped_ns_press = 1'b0;
    item_ch.ped_ew_press = 1'b0;
    item_ch.car_press    = 1'b0;
    item_ch.mode_switch  = MODE_SIMPLE;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ALL_RED_A;
    cfg_ch.data  = '0;

    // out of reset, simple mode, walk latch, then camera enter and leave
    plan.push_back(checked_row(0, 0, 0, MODE_SIMPLE,
      '{8'h24, 1'b0, 1'b0, PH_RR_A, MODE_SIMPLE, EV_NONE, 24'd0}));
    plan.push_back(checked_row(1, 1, 0, MODE_SIMPLE,
      '{8'h24, 1'b1, 1'b1, PH_RR_A, MODE_SIMPLE, EV_NONE, 24'd0}));
    plan.push_back(checked_row(0, 0, 1, MODE_CAMERA,
      '{8'h24, 1'b0, 1'b0, PH_RR_A, MODE_CAMERA, EV_SNAPSHOT, 24'd0}));
    plan.push_back(checked_row(0, 0, 1, MODE_CAMERA,
      '{8'h24, 1'b0, 1'b0, PH_RR_A, MODE_CAMERA, EV_LEFT, 24'd1}));
    plan.push_back(checked_row(0, 0, 1, MODE_CAMERA,
      '{8'h24, 1'b0, 1'b0, PH_RR_A, MODE_CAMERA, EV_SNAPSHOT, 24'd0}));
    repeat (3) plan.push_back(checked_row(0, 0, 0, MODE_CAMERA,
      '{8'h24, 1'b0, 1'b0, PH_RR_A, MODE_CAMERA, EV_NONE, 24'd0}));
    plan.push_back(checked_row(0, 0, 1, MODE_CAMERA,
      '{8'h24, 1'b0, 1'b0, PH_RR_A, MODE_CAMERA, EV_LEFT, 24'd4}));
    // zero periods count as 1 ms
    plan.push_back(cfg_row(REG_ALL_RED_A, 14'd0));
    plan.push_back(cfg_row(REG_GREEN_NS, 14'd2));
    plan.push_back(cfg_row(REG_YELLOW_NS, 14'd3));
    plan.push_back(cfg_row(REG_GRACE, 14'd0));
    // car ignored outside camera mode; walk shown on NS green
    plan.push_back(tick_row(1, 0, 1, MODE_CONFIG));
    repeat (6) plan.push_back(tick_row(0, 0, 0, MODE_CAMERA));
    plan.push_back(tick_row(0, 0, 0, MODE_CAMERA));
    // passed on green, armed on yellow, grace snapshot, leave, enter on red
    plan.push_back(tick_row(0, 0, 1, MODE_CAMERA));
    plan.push_back(tick_row(0, 0, 0, MODE_CAMERA));
    plan.push_back(tick_row(0, 0, 0, MODE_CAMERA));
    plan.push_back(tick_row(0, 0, 1, MODE_CAMERA));
    plan.push_back(tick_row(0, 0, 1, MODE_CAMERA));
    plan.push_back(tick_row(0, 0, 1, MODE_CAMERA));
    plan.push_back(tick_row(0, 1, 0, MODE_SIMPLE));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) cfg_write(plan[i].reg_idx, plan[i].reg_val);
      else send_tick(plan[i].ns, plan[i].ew, plan[i].car, plan[i].sw,
                     plan[i].typed, plan[i].want);
    end

    // random segments, mostly timed modes with short periods
    seg = 0;
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < RANDOM_TICKS || seg < MIN_SEGMENTS) begin
      seg++;
      if (seg == 5) begin
        while (cur_mode != MODE_SIMPLE) send_tick(1'b0, 1'b0, 1'b0, MODE_SIMPLE);
        load_periods(PROF_HIGH);
      end else if (seg == 1) begin
        load_periods(PROF_LOW);
      end else if (seg == 6 || seg % 4 == 1) begin
        load_periods(PROF_RANDOM);
      end
      rx_style = $urandom_range(RX_FREE, RX_BURSTY);
      gaps_on  = ($urandom_range(0, 3) != 0);
      if (seg % 10 == 3) hold_req = 1'b1;
      if (seg % 10 == 7) wait_drained();

      if (seg == 5) tgt = MODE_CAMERA;
      else if (seg == 6) tgt = MODE_CONFIG;
      else if ($urandom_range(0, 9) < 7) tgt = mode_t'($urandom_range(MODE_CONFIG, MODE_CAMERA));
      else tgt = mode_t'($urandom_range(MODE_SIMPLE, MODE_PED));
      len = (tgt == MODE_SIMPLE || tgt == MODE_PED) ? $urandom_range(2, 15)
                                                   : $urandom_range(20, 80);
      repeat (len) begin
        sw = ($urandom_range(0, 29) == 0) ? mode_t'($urandom_range(0, 3)) : tgt;
        send_tick($urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0,
                  $urandom_range(0, 7) == 0, sw);
      end
    end

    // long pedestrian-mode stretch to reach a fixed-period green
    load_periods(PROF_RANDOM);
    rx_style = RX_RANDOM;
    gaps_on = 1'b1;
    repeat (SOAK_TICKS)
      send_tick($urandom_range(0, 49) == 0, $urandom_range(0, 49) == 0,
                $urandom_range(0, 49) == 0, MODE_PED);

    item_ch.valid <= 1'b0;
    while (due_displays.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d ticks, %0d results, %0d register writes, %0d long receiver holds",
             ticks_sent, results_seen, cfg_writes, holds_done);
    $display("Camera: %0d snapshot, %0d armed, %0d on green, %0d left; %0d walk displays",
             ev_seen[EV_SNAPSHOT], ev_seen[EV_ARMED], ev_seen[EV_GREEN], ev_seen[EV_LEFT],
             walks_seen);
    if (errors == 0) begin
      $display("PASS traffic_light_ped_camera_ctrl");
    end else begin
      $display("FAIL traffic_light_ped_camera_ctrl");
    end
    $finish;
  end

endmodule
